>>> hw/rtl/yqr_pkg.sv
// Shared types, constants and helper functions for the 4:2:0 to RGB converter.
// No dependencies; used by the channel interfaces and by the top level.
package yqr_pkg;

    localparam int CHROMA_BIAS = 128;
    localparam int FRAC_BITS   = 10;
    localparam int PIX_MAX     = 8'hFF;

    localparam int COEF_W = 12;  // unsigned coefficient width
    localparam int TERM_W = 10;  // chroma term after the shift
    localparam int SUM_W  = 12;  // pixel sum before clamping

    // colour space codes
    localparam logic [1:0] CS_DEFAULT = 2'd0;
    localparam logic [1:0] CS_PAL     = 2'd1;
    localparam logic [1:0] CS_V4L2    = 2'd2;
    localparam logic [1:0] CS_NONE    = 2'd3;

    // coefficient selectors
    localparam logic [1:0] CO_V1 = 2'd0;
    localparam logic [1:0] CO_U1 = 2'd1;
    localparam logic [1:0] CO_V2 = 2'd2;
    localparam logic [1:0] CO_U2 = 2'd3;

    // register decode on paddr[2]
    localparam logic REG_COLOR_SPACE = 1'b0;
    localparam logic REG_SWAP_CHROMA = 1'b1;

    // pixel positions in emission order
    localparam logic [1:0] POS_TOP_LEFT     = 2'd0;
    localparam logic [1:0] POS_BOTTOM_RIGHT = 2'd3;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_first;
        logic [7:0] chroma_second;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] pixel_position;
        logic       last_of_block;
    } t_out_req;

    // Coefficients per 1024, scaled by the floor shift afterwards.
    function automatic logic [COEF_W-1:0] coef(input logic [1:0] cs, input logic [1:0] sel);
        logic [COEF_W-1:0] c;
        c = '0;
        case (cs)
            CS_DEFAULT: begin
                case (sel)
                    CO_V1:   c = 12'd1632;
                    CO_U1:   c = 12'd400;
                    CO_V2:   c = 12'd528;
                    default: c = 12'd2064;
                endcase
            end
            CS_PAL: begin
                case (sel)
                    CO_V1:   c = 12'd1168;
                    CO_U1:   c = 12'd408;
                    CO_V2:   c = 12'd594;
                    default: c = 12'd2080;
                endcase
            end
            CS_V4L2: begin
                case (sel)
                    CO_V1:   c = 12'd1440;
                    CO_U1:   c = 12'd352;
                    CO_V2:   c = 12'd736;
                    default: c = 12'd1816;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // coef * c, then arithmetic shift right (floor). Product fits in 20 bits.
    function automatic logic signed [TERM_W-1:0] term(input logic [COEF_W-1:0] k,
                                                      input logic signed [8:0] c);
        logic signed [COEF_W+9:0] p;
        p = $signed({1'b0, k}) * c;
        return p[FRAC_BITS+TERM_W-1:FRAC_BITS];
    endfunction

    function automatic logic [7:0] clamp(input logic signed [SUM_W-1:0] x);
        logic [7:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > $signed(SUM_W'(PIX_MAX))) begin
            r = 8'(PIX_MAX);
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/yqr_ifs.sv
// Valid/ready channel interfaces for the converter's block input and pixel output.
// Depends on yqr_pkg for the payload types.
interface yqr_in_if;
    logic             valid;
    logic             ready;
    yqr_pkg::t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface yqr_out_if;
    logic              valid;
    logic              ready;
    yqr_pkg::t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/yuv420_quad_to_rgb_unit.sv
// Top level of the 4:2:0 quad to RGB converter: APB registers, term stage, pixel stage.
// Depends on yqr_pkg and the channel interfaces in yqr_ifs.sv.
//
// One input request is a 2x2 luma block plus its shared chroma pair; it yields four
// pixel requests (top-left, bottom-left, top-right, bottom-right), the last flagged
// with last_of_block. An accepted block is held in the input register, and each
// pixel is formed from it into the output register. The output channel moves one
// pixel per cycle while ready is high; the held block gives out all four pixels
// before the next one is taken. The next block is taken in the same cycle as the
// fourth pixel of the current one is loaded, so with ready held high there are no
// gaps on the output. Chroma terms are formed once per block at input accept
// (constant-coefficient multiply, floor shift by 10) and held with the lumas; each
// colour is then one add (two subtracts for green), one compare pair for clamping,
// and the zero-luma override to black. Registers: color_space at 0x0, swap_chroma at
// 0x4; write them only while the block is idle. Reset is synchronous, active low.
module yuv420_quad_to_rgb_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    yqr_in_if.sink       i_in,
    yqr_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int TW = yqr_pkg::TERM_W;
    localparam int SW = yqr_pkg::SUM_W;

    // ---------------- configuration registers ----------------
    logic [1:0] r_color_space;
    logic       r_swap_chroma;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_space <= yqr_pkg::CS_DEFAULT;
            r_swap_chroma <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                yqr_pkg::REG_COLOR_SPACE: r_color_space <= pwdata[1:0];
                yqr_pkg::REG_SWAP_CHROMA: r_swap_chroma <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            yqr_pkg::REG_COLOR_SPACE: prdata = {30'd0, r_color_space};
            yqr_pkg::REG_SWAP_CHROMA: prdata = {31'd0, r_swap_chroma};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- term stage (input register) ----------------
    logic                 r_hold_valid;
    logic [1:0]           r_k;          // next pixel to emit from the held block
    logic [7:0]           r_luma [4];   // stored in emission order
    logic signed [TW-1:0] r_v1, r_u1, r_v2, r_u2;

    logic                 in_acc;
    logic                 take_pix;
    logic                 last_pix;
    logic signed [8:0]    c_first, c_second, c_u, c_v;

    // bias removal: 0..255 -> -128..127
    assign c_first  = $signed({1'b0, i_in.data.chroma_first})  - 9'sd128;
    assign c_second = $signed({1'b0, i_in.data.chroma_second}) - 9'sd128;
    assign c_u      = r_swap_chroma ? c_first  : c_second;
    assign c_v      = r_swap_chroma ? c_second : c_first;

    assign take_pix  = r_hold_valid && (!o_out.valid || o_out.ready);
    assign last_pix  = (r_k == yqr_pkg::POS_BOTTOM_RIGHT);
    assign i_in.ready = !r_hold_valid || (take_pix && last_pix);
    assign in_acc    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_k          <= yqr_pkg::POS_TOP_LEFT;
        end else begin
            if (in_acc) begin
                r_hold_valid <= 1'b1;
                r_k          <= yqr_pkg::POS_TOP_LEFT;
            end else if (take_pix) begin
                r_hold_valid <= !last_pix;
                r_k          <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_luma[0] <= i_in.data.luma_top_left;
            r_luma[1] <= i_in.data.luma_bottom_left;
            r_luma[2] <= i_in.data.luma_top_right;
            r_luma[3] <= i_in.data.luma_bottom_right;
            r_v1 <= yqr_pkg::term(yqr_pkg::coef(r_color_space, yqr_pkg::CO_V1), c_v);
            r_u1 <= yqr_pkg::term(yqr_pkg::coef(r_color_space, yqr_pkg::CO_U1), c_u);
            r_v2 <= yqr_pkg::term(yqr_pkg::coef(r_color_space, yqr_pkg::CO_V2), c_v);
            r_u2 <= yqr_pkg::term(yqr_pkg::coef(r_color_space, yqr_pkg::CO_U2), c_u);
        end
    end

    // ---------------- pixel stage (output register) ----------------
    logic                 r_out_valid;
    yqr_pkg::t_out_req    r_out;
    yqr_pkg::t_out_req    n_out;
    logic [7:0]           y;
    logic signed [SW-1:0] y_s, sum_r, sum_g, sum_b;

    assign y     = r_luma[r_k];
    assign y_s   = $signed({{(SW-8){1'b0}}, y});
    assign sum_r = y_s + SW'(r_v1);
    assign sum_g = y_s - SW'(r_u1) - SW'(r_v2);
    assign sum_b = y_s + SW'(r_u2);

    always_comb begin
        n_out.pixel_position = r_k;
        n_out.last_of_block  = last_pix;
        if (y == 8'd0) begin
            // black regardless of chroma
            n_out.red   = '0;
            n_out.green = '0;
            n_out.blue  = '0;
        end else begin
            n_out.red   = yqr_pkg::clamp(sum_r);
            n_out.green = yqr_pkg::clamp(sum_g);
            n_out.blue  = yqr_pkg::clamp(sum_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_pix) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_pix) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------- checks ----------------
    a_acc_fills_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_hold_valid && (r_k == yqr_pkg::POS_TOP_LEFT))
        else $error("accepted block not held");

    a_idle_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hold_valid |-> (r_k == yqr_pkg::POS_TOP_LEFT))
        else $error("pixel counter not at start while stage empty");

    a_pos_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.data.last_of_block)
        |=> o_out.valid && (o_out.data.pixel_position == $past(o_out.data.pixel_position) + 2'd1))
        else $error("pixel of block missing or out of order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        (o_out.data.last_of_block == (o_out.data.pixel_position == yqr_pkg::POS_BOTTOM_RIGHT)))
        else $error("last_of_block disagrees with position");

endmodule

>>> tb/tb_yuv420_quad_to_rgb_unit.sv
// Self-checking testbench for yuv420_quad_to_rgb_unit: 2x2 blocks in, RGB pixel requests out.
// Depends on yqr_pkg, the channel interfaces in yqr_ifs.sv and the top level RTL.
module tb_yuv420_quad_to_rgb_unit;
    import yqr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BLOCKS = 30;

    // Predicts the four pixels of each accepted block and holds them until they come out.
    class rgb_expectation;
        t_out_req   pending_pixels[$];
        logic [1:0] color_space;
        logic       swap_chroma;
        int         errors;

        function new();
            color_space = CS_DEFAULT;
            swap_chroma = 1'b0;
            errors      = 0;
        endfunction

        // the block keeps only the low bits of each register
        function void write_register(logic reg_sel, logic [31:0] value);
            if (reg_sel == REG_COLOR_SPACE) begin
                color_space = value[1:0];
            end else begin
                swap_chroma = value[0];
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function int limit8(int x);
            if (x < 0) begin
                return 0;
            end else if (x > PIX_MAX) begin
                return PIX_MAX;
            end
            return x;
        endfunction

        function void note_block(t_in_req blk);
            int       first, second, u, v;
            int       k_v1, k_u1, k_v2, k_u2;
            int       v1, u1, v2, u2;
            int       luma [4];
            t_out_req px;
            first  = blk.chroma_first;
            second = blk.chroma_second;
            first  = first - CHROMA_BIAS;
            second = second - CHROMA_BIAS;
            if (swap_chroma) begin
                u = first;
                v = second;
            end else begin
                v = first;
                u = second;
            end
            case (color_space)
                CS_DEFAULT: begin
                    k_v1 = 1632; k_u1 = 400; k_v2 = 528; k_u2 = 2064;
                end
                CS_PAL: begin
                    k_v1 = 1168; k_u1 = 408; k_v2 = 594; k_u2 = 2080;
                end
                CS_V4L2: begin
                    k_v1 = 1440; k_u1 = 352; k_v2 = 736; k_u2 = 1816;
                end
                default: begin
                    k_v1 = 0; k_u1 = 0; k_v2 = 0; k_u2 = 0;
                end
            endcase
            // signed int shift: floors negative products
            v1 = (k_v1 * v) >>> FRAC_BITS;
            u1 = (k_u1 * u) >>> FRAC_BITS;
            v2 = (k_v2 * v) >>> FRAC_BITS;
            u2 = (k_u2 * u) >>> FRAC_BITS;
            luma[0] = blk.luma_top_left;
            luma[1] = blk.luma_bottom_left;
            luma[2] = blk.luma_top_right;
            luma[3] = blk.luma_bottom_right;
            for (int p = 0; p < 4; p++) begin
                if (luma[p] == 0) begin
                    px.red   = '0;
                    px.green = '0;
                    px.blue  = '0;
                end else begin
                    px.red   = 8'(limit8(luma[p] + v1));
                    px.green = 8'(limit8(luma[p] - u1 - v2));
                    px.blue  = 8'(limit8(luma[p] + u2));
                end
                px.pixel_position = 2'(p);
                px.last_of_block  = (px.pixel_position == POS_BOTTOM_RIGHT);
                pending_pixels.push_back(px);
            end
        endfunction

        function void compare_field(string field, int p, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s of pixel %0d: expected %0d, got %0d",
                         $time, field, p, want, got);
            end
        endfunction

        function void check_pixel(t_out_req got);
            t_out_req want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel request with nothing expected: expected none, got %h",
                         $time, got);
            end else begin
                want = pending_pixels.pop_front();
                compare_field("red", want.pixel_position, want.red, got.red);
                compare_field("green", want.pixel_position, want.green, got.green);
                compare_field("blue", want.pixel_position, want.blue, got.blue);
                compare_field("pixel_position", want.pixel_position,
                              want.pixel_position, got.pixel_position);
                compare_field("last_of_block", want.pixel_position,
                              want.last_of_block, got.last_of_block);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    yqr_in_if  in_ch();
    yqr_out_if out_ch();

    yuv420_quad_to_rgb_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rgb_expectation expected_rgb;
    int             cycles;
    int             rx_wait;
    // when set, neither side idles: back-to-back requests at full rate
    bit             calm;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Biased byte: extremes and values around the chroma bias turn up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(126, 130));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_req random_block();
        t_in_req blk;
        blk.luma_top_left     = pick_byte();
        blk.luma_top_right    = pick_byte();
        blk.luma_bottom_left  = pick_byte();
        blk.luma_bottom_right = pick_byte();
        blk.chroma_first      = pick_byte();
        blk.chroma_second     = pick_byte();
        return blk;
    endfunction

    // Hand-picked blocks: black override, clamping at both ends, zero chroma,
    // and products of -1 that must floor rather than truncate.
    function automatic t_in_req directed_block(int n);
        t_in_req blk;
        case (n)
            0:       blk = {8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0};
            1:       blk = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
            2:       blk = {8'd1,   8'd2,   8'd3,   8'd4,   8'd0,   8'd0};
            3:       blk = {8'd0,   8'd255, 8'd1,   8'd128, 8'd128, 8'd128};
            4:       blk = {8'd100, 8'd150, 8'd200, 8'd50,  8'd127, 8'd129};
            default: blk = {8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255};
        endcase
        return blk;
    endfunction

    // Output side: count down the drawn stall, then hold ready until the next request.
    always @(negedge i_clk) begin
        out_ch.ready <= (rx_wait == 0);
        if (rx_wait > 0) begin
            rx_wait--;
        end
    end

    // Pixel monitor and watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            expected_rgb.check_pixel(out_ch.data);
            rx_wait = draw_wait();
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Two-phase APB write; random upper bits check that only the low bits are kept.
    task automatic program_register(logic reg_sel, logic [1:0] field);
        logic [31:0] value;
        value = $urandom();
        if (reg_sel == REG_COLOR_SPACE) begin
            value[1:0] = field;
        end else begin
            value[0] = field[0];
        end
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        expected_rgb.write_register(reg_sel, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(logic [1:0] cs, logic swap);
        program_register(REG_COLOR_SPACE, cs);
        program_register(REG_SWAP_CHROMA, {1'b0, swap});
    endtask

    // Offer one block after the drawn gap; valid stays up when the gap is zero.
    task automatic send_block(t_in_req blk);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  <= blk;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_rgb.note_block(blk);
    endtask

    // Stop sending and wait for every predicted pixel to come out.
    task automatic wait_for_pixels();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_rgb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] cs;
        logic       swap;
        expected_rgb = new();
        cycles       = 0;
        rx_wait      = 0;
        calm         = 1'b0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed blocks under four settings, covering every colour space
        for (int s = 0; s < 4; s++) begin
            case (s)
                0:       set_mode(CS_DEFAULT, 1'b0);
                1:       set_mode(CS_PAL, 1'b1);
                2:       set_mode(CS_V4L2, 1'b0);
                default: set_mode(CS_NONE, 1'b1);
            endcase
            for (int n = 0; n < 6; n++) begin
                send_block(directed_block(n));
            end
            wait_for_pixels();
        end

        // random phases: first all eight settings in turn, then a random one
        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 8) begin
                cs   = 2'(ph);
                swap = ph[2];
            end else begin
                cs   = 2'($urandom_range(0, 3));
                swap = 1'($urandom_range(0, 1));
            end
            set_mode(cs, swap);
            for (int n = 0; n < PHASE_BLOCKS; n++) begin
                // a stretch at full rate in the middle of each phase
                calm = (n >= 10 && n < 20);
                if (ph == 4 && n == 15) begin
                    wait_for_pixels();
                end
                send_block(random_block());
            end
            calm = 1'b0;
            wait_for_pixels();
        end

        // let any stray request surface before judging
        repeat (8) @(posedge i_clk);
        if (expected_rgb.pending() != 0) begin
            expected_rgb.errors++;
            $display("%0t: pixels still outstanding: expected 0, got %0d",
                     $time, expected_rgb.pending());
        end
        if (expected_rgb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/yqr_pkg.sv
hw/rtl/yqr_ifs.sv
hw/rtl/yuv420_quad_to_rgb_unit.sv
tb/tb_yuv420_quad_to_rgb_unit.sv
